// ===== src/crcp_pkg.sv =====
`default_nettype none

package crcp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PW = 32;
    localparam int NW = PW + FRAC_BITS;
    localparam int D_LIM_BITS = 40;
    localparam int DW = D_LIM_BITS + 2;
    localparam int XW = DW + 2;
    localparam int YW = XW + 9;
    localparam int BQ_STEPS = 8;
    localparam int LAT = NW + 14;
    localparam int ADDR_W = 4;

    localparam logic [7:0] HALF_BYTE = 8'd127;
    localparam logic [7:0] FULL_BYTE = 8'd255;

    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_UNITS  = 2'd1,
        REG_MAX    = 2'd2,
        REG_ALPHA  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [PW-1:0] offset;
        logic [PW-1:0]        units;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/crcp_pix_in_if.sv =====
`default_nettype none

interface crcp_pix_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] real_part;
    logic [31:0] imag_part;
    logic [31:0] total_weight;

    modport source (output valid, output real_part, output imag_part, output total_weight,
                    input ready);
    modport sink (input valid, input real_part, input imag_part, input total_weight,
                  output ready);
endinterface

`default_nettype wire

// ===== src/crcp_pix_out_if.sv =====
`default_nettype none

interface crcp_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

`default_nettype wire

// ===== src/crcp_lane.sv =====
`default_nettype none

module crcp_lane import crcp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [PW-1:0] i_part,
    input  wire logic [PW-1:0]        i_total,
    input  wire t_cfg                 i_cfg,
    output logic [7:0]                o_byte
);

    localparam int BW = NW + 2;
    localparam logic signed [BW-1:0] D_HI = BW'(1) << D_LIM_BITS;
    localparam logic signed [BW-1:0] D_LO = -D_HI;

    logic [PW-1:0] r_rem [0:NW];
    logic [NW-1:0] r_dq  [0:NW];
    logic [PW-1:0] r_t   [0:NW-1];
    logic          r_neg [0:NW];
    logic          r_pz  [0:NW];
    logic          r_tz  [0:NW];

    logic [PW-1:0] w_mag;

    assign w_mag = i_part[PW-1] ? PW'(~i_part + PW'(1)) : PW'(i_part);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dq[0]  <= {w_mag, {FRAC_BITS{1'b0}}};
            r_t[0]   <= i_total;
            r_neg[0] <= i_part[PW-1];
            r_pz[0]  <= (i_part == '0);
            r_tz[0]  <= (i_total == '0);
        end
    end

    for (genvar g_k = 1; g_k <= NW; g_k++) begin : g_div
        logic [PW:0] w_t;
        logic        w_ge;

        assign w_t  = {r_rem[g_k-1], r_dq[g_k-1][NW-1]};
        assign w_ge = w_t >= {1'b0, r_t[g_k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g_k] <= w_ge ? PW'(w_t - {1'b0, r_t[g_k-1]}) : w_t[PW-1:0];
                r_dq[g_k]  <= {r_dq[g_k-1][NW-2:0], w_ge};
                r_neg[g_k] <= r_neg[g_k-1];
                r_pz[g_k]  <= r_pz[g_k-1];
                r_tz[g_k]  <= r_tz[g_k-1];
            end
        end

        if (g_k < NW) begin : g_tot
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_t[g_k] <= r_t[g_k-1];
                end
            end
        end
    end

    // Floor of the signed quotient, with the zero-total cases set aside.
    logic [NW:0]        w_qmag;
    logic signed [NW:0] r_qa;
    logic               r_ova;
    logic [7:0]         r_ovva;

    assign w_qmag = {1'b0, r_dq[NW]} + (NW+1)'(r_neg[NW] && (r_rem[NW] != '0));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qa   <= r_neg[NW] ? -$signed(w_qmag) : $signed(w_qmag);
            r_ova  <= r_tz[NW];
            r_ovva <= r_pz[NW] ? HALF_BYTE : (r_neg[NW] ? 8'd0 : FULL_BYTE);
        end
    end

    logic signed [BW-1:0] w_d;
    logic signed [DW-1:0] w_ds;
    logic signed [DW-1:0] r_db;
    logic                 r_ovb;
    logic [7:0]           r_ovvb;

    assign w_d  = BW'(r_qa) - BW'(i_cfg.offset);
    assign w_ds = (w_d > D_HI) ? DW'(D_HI) : ((w_d < D_LO) ? DW'(D_LO) : DW'(w_d));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_db <= w_ds;
            if (r_ova) begin
                r_ovb  <= 1'b1;
                r_ovvb <= r_ovva;
            end else begin
                r_ovb  <= (i_cfg.units == '0);
                r_ovvb <= (w_ds == '0) ? HALF_BYTE : ((w_ds > 0) ? FULL_BYTE : 8'd0);
            end
        end
    end

    logic [XW-1:0] w_x;
    logic [XW-2:0] r_x;
    logic          r_ovc;
    logic [7:0]    r_ovvc;

    assign w_x = (XW'(r_db) << 1) + XW'(i_cfg.units);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= w_x[XW-2:0];
            r_ovc  <= r_ovb | w_x[XW-1];
            r_ovvc <= r_ovb ? r_ovvb : 8'd0;
        end
    end

    logic [YW-1:0] r_y    [0:8];
    logic          r_eov  [0:9];
    logic [7:0]    r_eovv [0:9];
    logic [7:0]    r_qb   [1:9];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0]    <= (YW'(r_x) << 8) - YW'(r_x);
            r_eov[0]  <= r_ovc;
            r_eovv[0] <= r_ovvc;
        end
    end

    for (genvar g_j = 1; g_j <= 9; g_j++) begin : g_quo
        localparam int K = 9 - g_j;
        logic [YW-1:0] w_dv;
        logic          w_ge;

        assign w_dv = YW'(i_cfg.units) << (K + 1);
        assign w_ge = r_y[g_j-1] >= w_dv;

        if (g_j < 9) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[g_j] <= w_ge ? (r_y[g_j-1] - w_dv) : r_y[g_j-1];
                end
            end
        end

        if (g_j == 1) begin : g_sat
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_qb[g_j]   <= '0;
                    r_eov[g_j]  <= r_eov[g_j-1] | w_ge;
                    r_eovv[g_j] <= r_eov[g_j-1] ? r_eovv[g_j-1] : FULL_BYTE;
                end
            end
        end else begin : g_bit
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_qb[g_j]   <= {r_qb[g_j-1][6:0], w_ge};
                    r_eov[g_j]  <= r_eov[g_j-1];
                    r_eovv[g_j] <= r_eovv[g_j-1];
                end
            end
        end
    end

    assign o_byte = r_eov[9] ? r_eovv[9] : r_qb[9];

endmodule

`default_nettype wire

// ===== src/complex_ratio_colormap_pixel_core.sv =====
// Throughput: one pixel per cycle while the output is accepted; a single pipeline enable stalls all stages together.
// The long path is a bit-per-stage restoring divider for part * 2^FRAC_BITS / total.
// Reset is synchronous and active low; it clears the stage valid bits and loads the
// register defaults (offset 0, units 1.0, max_total 1.0 in Q16.16, alpha 255).
`default_nettype none

module complex_ratio_colormap_pixel_core import crcp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    crcp_pix_in_if.sink            i_pix,
    crcp_pix_out_if.source         o_pix,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic signed [PW-1:0] r_offset;
    logic [PW-1:0]        r_units;
    logic [PW-1:0]        r_max;
    logic [7:0]           r_alpha;
    t_reg_idx             w_idx;
    t_cfg                 w_cfg;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_cfg  = '{offset: r_offset, units: r_units};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_units  <= PW'(1) << FRAC_BITS;
            r_max    <= PW'(1) << FRAC_BITS;
            r_alpha  <= FULL_BYTE;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_OFFSET: r_offset <= pwdata;
                REG_UNITS:  r_units  <= pwdata;
                REG_MAX:    r_max    <= pwdata;
                REG_ALPHA:  r_alpha  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_OFFSET: prdata = r_offset;
            REG_UNITS:  prdata = r_units;
            REG_MAX:    prdata = r_max;
            REG_ALPHA:  prdata = {24'd0, r_alpha};
            default:    prdata = '0;
        endcase
    end

    logic r_vld [0:LAT-1];
    logic w_en;

    assign w_en        = !r_vld[LAT-1] || o_pix.ready;
    assign i_pix.ready = w_en;
    assign o_pix.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_pix.valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    crcp_lane u_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_part  (i_pix.real_part),
        .i_total (i_pix.total_weight),
        .i_cfg   (w_cfg),
        .o_byte  (o_pix.red)
    );

    crcp_lane u_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_part  (i_pix.imag_part),
        .i_total (i_pix.total_weight),
        .i_cfg   (w_cfg),
        .o_byte  (o_pix.green)
    );

    logic [PW-1:0] r_brem [0:BQ_STEPS-1];
    logic [7:0]    r_bq   [1:LAT-1];
    logic          r_bov  [0:LAT-1];
    logic [7:0]    r_bovv [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_brem[0] <= i_pix.total_weight;
            r_bov[0]  <= (r_max == '0) || (i_pix.total_weight >= r_max);
            r_bovv[0] <= ((r_max == '0) && (i_pix.total_weight == '0)) ? 8'd0 : FULL_BYTE;
        end
    end

    for (genvar g_j = 1; g_j < LAT; g_j++) begin : g_blue
        if (g_j <= BQ_STEPS) begin : g_step
            logic [PW:0] w_t;
            logic        w_ge;

            assign w_t  = {r_brem[g_j-1], 1'b0};
            assign w_ge = w_t >= {1'b0, r_max};

            if (g_j < BQ_STEPS) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_brem[g_j] <= w_ge ? PW'(w_t - {1'b0, r_max}) : w_t[PW-1:0];
                    end
                end
            end

            if (g_j == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_bq[g_j] <= {7'd0, w_ge};
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_bq[g_j] <= {r_bq[g_j-1][6:0], w_ge};
                    end
                end
            end
        end else begin : g_delay
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_bq[g_j] <= r_bq[g_j-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_bov[g_j]  <= r_bov[g_j-1];
                r_bovv[g_j] <= r_bovv[g_j-1];
            end
        end
    end

    assign o_pix.blue  = r_bov[LAT-1] ? r_bovv[LAT-1] : r_bq[LAT-1];
    assign o_pix.alpha = r_alpha;

endmodule

`default_nettype wire

// ===== src/crcp_checker.sv =====
`default_nettype none

module crcp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result transaction dropped while stalled.");

    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stall.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("Configuration port inserted a wait state.");

endmodule

bind complex_ratio_colormap_pixel_core crcp_checker u_crcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pready    (pready)
);

`default_nettype wire
